// File: rtl/dct8_pkg.sv
`timescale 1ns / 1ps

package dct8_pkg;

    // sample and datapath widths
    localparam int SAMPLE_W = 24;
    localparam int INT_W    = SAMPLE_W + 6;
    localparam int OUT_W    = 32;
    localparam int FRAC_W   = 32;

    // 32.32 constants split into a small integer part and a 32-bit fraction
    localparam int                K_FWD0_HI = 0;
    localparam logic [FRAC_W-1:0] K_FWD0_LO = 32'h61F78A9B;
    localparam int                K_FWD1_HI = 0;
    localparam logic [FRAC_W-1:0] K_FWD1_LO = 32'h8A8BD3DF;
    localparam int                K_FWD2_HI = 0;
    localparam logic [FRAC_W-1:0] K_FWD2_LO = 32'hB504F334;
    localparam int                K_FWD3_HI = 1;
    localparam logic [FRAC_W-1:0] K_FWD3_LO = 32'h4E7AE914;
    localparam int                K_INV0_HI = 0;
    localparam logic [FRAC_W-1:0] K_INV0_LO = 32'hC3EF1535;
    localparam int                K_INV1_HI = -3;
    localparam logic [FRAC_W-1:0] K_INV1_LO = 32'h630A2DD7;
    localparam int                K_INV2_HI = 1;
    localparam logic [FRAC_W-1:0] K_INV2_LO = 32'h1517A7BE;
    localparam int                K_INV3_HI = 1;
    localparam logic [FRAC_W-1:0] K_INV3_LO = 32'h6A09E668;

    // op codes
    localparam logic OP_FWD = 1'b0;
    localparam logic OP_INV = 1'b1;

    typedef logic signed [INT_W-1:0] t_int;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] x0;
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] x3;
        logic signed [SAMPLE_W-1:0] x4;
        logic signed [SAMPLE_W-1:0] x5;
        logic signed [SAMPLE_W-1:0] x6;
        logic signed [SAMPLE_W-1:0] x7;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] y0;
        logic signed [OUT_W-1:0] y1;
        logic signed [OUT_W-1:0] y2;
        logic signed [OUT_W-1:0] y3;
        logic signed [OUT_W-1:0] y4;
        logic signed [OUT_W-1:0] y5;
        logic signed [OUT_W-1:0] y6;
        logic signed [OUT_W-1:0] y7;
    } t_out;

endpackage

// File: rtl/dct8_fixed_point.sv
`timescale 1ns / 1ps
// an accepted input beat passes the input register and then the output register before it leaves as a result beat
// throughput: one beat per cycle while the output is not stalled, input register then output register
// the critical path runs through the input butterflies, a 30x33 constant multiply and the output adds
// reset: synchronous active low, clears both valid flags; payload registers not reset
module dct8_fixed_point import dct8_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic r_stg_vld, n_stg_vld;
    logic r_out_vld, n_out_vld;
    t_in  r_stg, n_stg;
    t_out r_out, n_out;
    logic w_out_free, w_stg_rdy;
    t_out w_fwd, w_inv, w_res;

    // stage enables
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_stg_rdy  = !r_stg_vld || w_out_free;

    // transform datapaths
    dct8_fwd u_fwd (.i_item(r_stg), .o_res(w_fwd));
    dct8_inv u_inv (.i_item(r_stg), .o_res(w_inv));

    always_comb begin
        case (r_stg.op)
            OP_FWD:  w_res = w_fwd;
            OP_INV:  w_res = w_inv;
            default: w_res = w_fwd;
        endcase
    end

    // next state
    always_comb begin
        n_stg_vld = r_stg_vld;
        n_out_vld = r_out_vld;
        n_stg     = r_stg;
        n_out     = r_out;
        if (w_stg_rdy) begin
            n_stg_vld = i_in_valid;
            n_stg     = i_in_data;
        end
        if (w_out_free) begin
            n_out_vld = r_stg_vld;
            n_out     = w_res;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_stg_vld <= n_stg_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_stg <= n_stg;
        r_out <= n_out;
    end

    assign o_in_ready  = w_stg_rdy;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: rtl/dct8_cmul.sv
`timescale 1ns / 1ps

module dct8_cmul import dct8_pkg::*; #(
    parameter int                K_HI = 0,
    parameter logic [FRAC_W-1:0] K_LO = '0
) (
    input  t_int i_val,
    output t_int o_prod
);

    localparam int PW = INT_W + FRAC_W + 1;
    localparam int HW = INT_W + 3;

    logic signed [PW-1:0] w_frac_prod;
    logic signed [HW-1:0] w_hi_prod;
    logic signed [INT_W:0] w_frac;

    // fraction part, floored by dropping the low 32 bits
    assign w_frac_prod = PW'(i_val) * PW'($signed({1'b0, K_LO}));
    assign w_frac      = w_frac_prod[PW-1:FRAC_W];

    // integer part of the constant is a small signed factor
    assign w_hi_prod = HW'(i_val) * HW'(K_HI);

    assign o_prod = INT_W'(w_hi_prod) + INT_W'(w_frac);

endmodule

// File: rtl/dct8_fwd.sv
`timescale 1ns / 1ps

module dct8_fwd import dct8_pkg::*; (
    input  t_in  i_item,
    output t_out o_res
);

    t_int x0, x1, x2, x3, x4, x5, x6, x7;
    t_int a0, a1, a2, a3, a4, a5, a6, a7;
    t_int e0, e1, e2, e3, e4, e5, e6;
    t_int s_e1, s_c0, s_d0;
    t_int c0, d0, d1, d2, d3, d4, p1, p2;
    t_int f0, f1, f2, f3, f4, f5, f6, f7;

    // sign extend samples
    assign x0 = INT_W'(i_item.x0);
    assign x1 = INT_W'(i_item.x1);
    assign x2 = INT_W'(i_item.x2);
    assign x3 = INT_W'(i_item.x3);
    assign x4 = INT_W'(i_item.x4);
    assign x5 = INT_W'(i_item.x5);
    assign x6 = INT_W'(i_item.x6);
    assign x7 = INT_W'(i_item.x7);

    // first butterfly
    assign a0 = x0 + x7;
    assign a1 = x1 + x6;
    assign a2 = x2 + x5;
    assign a3 = x3 + x4;
    assign a4 = x3 - x4;
    assign a5 = x2 - x5;
    assign a6 = x1 - x6;
    assign a7 = x0 - x7;

    // second butterfly
    assign e0 = a4 + a5;
    assign e2 = a6 + a7;
    assign e3 = a0 + a3;
    assign e4 = a1 + a2;
    assign e5 = a1 - a2;
    assign e6 = a0 - a3;

    // multiplier operands
    assign s_e1 = a5 + a6;
    assign s_c0 = e2 - e0;
    assign s_d0 = e5 + e6;

    // constant multipliers
    dct8_cmul #(.K_HI(K_FWD2_HI), .K_LO(K_FWD2_LO)) u_mul_e1 (.i_val(s_e1), .o_prod(e1));
    dct8_cmul #(.K_HI(K_FWD0_HI), .K_LO(K_FWD0_LO)) u_mul_c0 (.i_val(s_c0), .o_prod(c0));
    dct8_cmul #(.K_HI(K_FWD2_HI), .K_LO(K_FWD2_LO)) u_mul_d0 (.i_val(s_d0), .o_prod(d0));
    dct8_cmul #(.K_HI(K_FWD1_HI), .K_LO(K_FWD1_LO)) u_mul_d1 (.i_val(e0),   .o_prod(p1));
    dct8_cmul #(.K_HI(K_FWD3_HI), .K_LO(K_FWD3_LO)) u_mul_d2 (.i_val(e2),   .o_prod(p2));

    // odd part
    assign d3 = a7 + e1;
    assign d4 = a7 - e1;
    assign d1 = p1 - c0;
    assign d2 = p2 - c0;

    // output butterfly
    assign f0 = e3 + e4;
    assign f1 = d3 + d2;
    assign f2 = d0 + e6;
    assign f3 = d4 - d1;
    assign f4 = e3 - e4;
    assign f5 = d1 + d4;
    assign f6 = e6 - d0;
    assign f7 = d3 - d2;

    // final scale by 1/8, floored
    assign o_res.y0 = OUT_W'(f0 >>> 3);
    assign o_res.y1 = OUT_W'(f1 >>> 3);
    assign o_res.y2 = OUT_W'(f2 >>> 3);
    assign o_res.y3 = OUT_W'(f3 >>> 3);
    assign o_res.y4 = OUT_W'(f4 >>> 3);
    assign o_res.y5 = OUT_W'(f5 >>> 3);
    assign o_res.y6 = OUT_W'(f6 >>> 3);
    assign o_res.y7 = OUT_W'(f7 >>> 3);

endmodule

// File: rtl/dct8_inv.sv
`timescale 1ns / 1ps

module dct8_inv import dct8_pkg::*; (
    input  t_in  i_item,
    output t_out o_res
);

    t_int x0, x1, x2, x3, x4, x5, x6, x7;
    t_int a0, a1, a2, a3, a4, a5, a6, a7;
    t_int m0, m1, m2, m3, m4, m5, s_m4;
    t_int p_m5, p_n2, p_n3, p_p0;
    t_int n0, n1, n2, n3, o0, p0, q0;

    // sign extend samples
    assign x0 = INT_W'(i_item.x0);
    assign x1 = INT_W'(i_item.x1);
    assign x2 = INT_W'(i_item.x2);
    assign x3 = INT_W'(i_item.x3);
    assign x4 = INT_W'(i_item.x4);
    assign x5 = INT_W'(i_item.x5);
    assign x6 = INT_W'(i_item.x6);
    assign x7 = INT_W'(i_item.x7);

    // first butterfly
    assign a0 = x0 + x4;
    assign a1 = x2 + x6;
    assign a2 = x2 - x6;
    assign a3 = x0 - x4;
    assign a4 = x1 + x7;
    assign a5 = x5 + x3;
    assign a7 = x5 - x3;
    assign a6 = x1 - x7;

    // second butterfly
    assign m0   = a0 + a1;
    assign m1   = a0 - a1;
    assign m2   = a4 + a5;
    assign m3   = a4 - a5;
    assign s_m4 = a7 - a6;

    // constant multipliers
    dct8_cmul #(.K_HI(K_INV0_HI), .K_LO(K_INV0_LO)) u_mul_m4 (.i_val(s_m4), .o_prod(m4));
    dct8_cmul #(.K_HI(K_INV3_HI), .K_LO(K_INV3_LO)) u_mul_m5 (.i_val(a2),   .o_prod(p_m5));
    dct8_cmul #(.K_HI(K_INV1_HI), .K_LO(K_INV1_LO)) u_mul_n2 (.i_val(a7),   .o_prod(p_n2));
    dct8_cmul #(.K_HI(K_INV2_HI), .K_LO(K_INV2_LO)) u_mul_n3 (.i_val(a6),   .o_prod(p_n3));
    dct8_cmul #(.K_HI(K_INV3_HI), .K_LO(K_INV3_LO)) u_mul_p0 (.i_val(m3),   .o_prod(p_p0));

    // odd and even recombination
    assign m5 = p_m5 - a1;
    assign n0 = a3 + m5;
    assign n1 = a3 - m5;
    assign n2 = p_n2 + m4;
    assign n3 = p_n3 - m4;
    assign o0 = n3 - m2;
    assign p0 = p_p0 - o0;
    assign q0 = -p0 - n2;

    // output butterfly, no final scale
    assign o_res.y0 = OUT_W'(m0 + m2);
    assign o_res.y1 = OUT_W'(n0 + o0);
    assign o_res.y2 = OUT_W'(n1 + p0);
    assign o_res.y3 = OUT_W'(m1 + q0);
    assign o_res.y4 = OUT_W'(m1 - q0);
    assign o_res.y5 = OUT_W'(n1 - p0);
    assign o_res.y6 = OUT_W'(n0 - o0);
    assign o_res.y7 = OUT_W'(m0 - m2);

endmodule

// File: rtl/dct8_chk.sv
`timescale 1ns / 1ps

module dct8_chk import dct8_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a stalled result beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result data changed while stalled");

    // reset empties the output side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // with the output side empty the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind dct8_fixed_point dct8_chk u_chk (.*);
